// ===== hdl/key_delimited_value_extractor_unit_assert.svh =====
// assertion macros shared by the extractor rtl
`ifndef KEY_DELIMITED_VALUE_EXTRACTOR_UNIT_ASSERT_SVH
`define KEY_DELIMITED_VALUE_EXTRACTOR_UNIT_ASSERT_SVH

// checked on i_clk, skipped while reset is held
`define KDVE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kdve assertion failed");

// checked on i_clk at every edge, reset included
`define KDVE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("kdve assertion failed");

`endif

// ===== hdl/kdve_pkg.sv =====
package kdve_pkg;

    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_W         = 64;
    localparam int KEY_LEN_W     = 4;
    localparam int OFFSET_W      = 32;
    localparam int BYTE_W        = 8;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_START_KEY     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_KEY_LEN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_KEY       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_KEY_LEN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SKIP_OFFSET   = 3'd4;

    typedef enum logic [1:0] {
        KIND_VALUE     = 2'd0,
        KIND_END_FOUND = 2'd1,
        KIND_NO_START  = 2'd2,
        KIND_NO_END    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        PH_SKIP    = 4'b0001,
        PH_SEARCH  = 4'b0010,
        PH_EXTRACT = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    // key bytes a cell compares against, with enables for cells past the key length
    typedef struct packed {
        logic [BYTE_W-1:0] start_kb;
        logic              start_en;
        logic [BYTE_W-1:0] end_kb;
        logic              end_en;
    } t_cell_key;

    typedef struct packed {
        logic start_eq;
        logic end_eq;
    } t_cell_hit;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   value_byte;
        logic [OFFSET_W-1:0] end_offset;
    } t_result;

endpackage

// ===== hdl/kdve_cell.sv =====
module kdve_cell (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [kdve_pkg::BYTE_W-1:0] i_byte,
    input  kdve_pkg::t_cell_key        i_key,
    output logic [kdve_pkg::BYTE_W-1:0] o_byte,
    output kdve_pkg::t_cell_hit        o_hit
);

    logic [kdve_pkg::BYTE_W-1:0] r_byte;

    // compare the byte this cell takes in, ahead of the shift
    always_comb begin
        o_hit.start_eq = !i_key.start_en || (i_byte == i_key.start_kb);
        o_hit.end_eq   = !i_key.end_en || (i_byte == i_key.end_kb);
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== hdl/key_delimited_value_extractor_unit.sv =====
// key delimited value extractor
// input stream: one byte per transfer on s_axis_tdata, s_axis_tlast on the final
// byte of a stream. bytes below skip_offset are passed over, then the start key
// is searched; bytes after it come out as value results until the end key is
// seen, which gives an end-found result with the offset of its first byte.
// a stream that ends early gives a no-start or no-end result instead, and the
// value bytes already sent are to be dropped by the consumer.
// output: kind on m_axis_tuser, value byte and end offset on m_axis_tdata,
// m_axis_tlast on the final result of a stream. a value byte comes out end key
// length minus one transfers behind its own, since it leaves from the far end
// of the compare window.
// results are registered into the output buffer. one byte is taken every cycle
// while s_axis_tready is high, set by the shift and compare of the cell row.
// each byte gives at most one result. a two-entry output buffer lets input flow
// on while one result waits; s_axis_tready drops only when both entries are full.
// reset clears the registers to their defaults and starts a new stream; after the
// final byte of a stream the stream state returns to the same point. registers are
// to be written over i_cfg_* only while the block is idle; it does not check this.
`include "key_delimited_value_extractor_unit_assert.svh"

module key_delimited_value_extractor_unit #(
    parameter int MAX_KEY_BYTES = kdve_pkg::MAX_KEY_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kdve_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [kdve_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // data_byte
    input  logic                            s_axis_tlast,  // stream_end
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [39:0]                     m_axis_tdata,  // value_byte, end_offset
    output logic [1:0]                      m_axis_tuser,  // kind
    output logic                            m_axis_tlast   // last
);

    localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
    localparam int IW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int BW  = kdve_pkg::BYTE_W;
    localparam int OW  = kdve_pkg::OFFSET_W;
    localparam int KLW = kdve_pkg::KEY_LEN_W;

    logic [kdve_pkg::KEY_W-1:0]     r_start_key;
    logic [kdve_pkg::KEY_LEN_W-1:0] r_start_len;
    logic [kdve_pkg::KEY_W-1:0]     r_end_key;
    logic [kdve_pkg::KEY_LEN_W-1:0] r_end_len;
    logic [OW-1:0]                  r_skip;

    kdve_pkg::t_phase r_phase, n_phase, w_ph_eff;
    logic [LW-1:0]    r_fill, n_fill, w_fill_p;
    logic [OW-1:0]    r_offset, n_offset;

    logic [LW-1:0] w_slen, w_elen;
    logic [IW-1:0] w_elen_m1;
    logic          w_accept, w_shift;
    logic          w_start_all, w_end_all;
    logic [BW-1:0] w_value;

    logic              w_res_v;
    kdve_pkg::t_result w_res;
    logic              w_found_end;

    logic              r_out_valid, r_skid_valid;
    kdve_pkg::t_result r_out, r_skid;
    logic              w_pop, w_push;

    kdve_pkg::t_cell_key         w_key [MAX_KEY_BYTES];
    kdve_pkg::t_cell_hit         w_hit [MAX_KEY_BYTES];
    logic [BW-1:0]               w_win_in [MAX_KEY_BYTES];
    logic [BW-1:0]               w_win_out [MAX_KEY_BYTES];
    logic [MAX_KEY_BYTES-1:0]    w_start_eq, w_end_eq;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_key <= '0;
            r_start_len <= KLW'(1);
            r_end_key   <= '0;
            r_end_len   <= KLW'(1);
            r_skip      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                kdve_pkg::CFG_START_KEY:     r_start_key <= i_cfg_data;
                kdve_pkg::CFG_START_KEY_LEN: r_start_len <= i_cfg_data[KLW-1:0];
                kdve_pkg::CFG_END_KEY:       r_end_key   <= i_cfg_data;
                kdve_pkg::CFG_END_KEY_LEN:   r_end_len   <= i_cfg_data[KLW-1:0];
                kdve_pkg::CFG_SKIP_OFFSET:   r_skip      <= i_cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    // zero length counts as one, anything above the cell count as the cell count
    always_comb begin
        if (r_start_len == '0) begin
            w_slen = LW'(1);
        end else if (r_start_len > KLW'(MAX_KEY_BYTES)) begin
            w_slen = LW'(MAX_KEY_BYTES);
        end else begin
            w_slen = r_start_len[LW-1:0];
        end
        if (r_end_len == '0) begin
            w_elen = LW'(1);
        end else if (r_end_len > KLW'(MAX_KEY_BYTES)) begin
            w_elen = LW'(MAX_KEY_BYTES);
        end else begin
            w_elen = r_end_len[LW-1:0];
        end
    end

    assign w_elen_m1 = IW'(w_elen - LW'(1));

    // cell k holds the k-th most recent byte and faces key byte len-1-k
    for (genvar k = 0; k < MAX_KEY_BYTES; k++) begin : g_cell
        logic [LW-1:0]              w_spos, w_epos;
        logic [kdve_pkg::KEY_W-1:0] w_ssh, w_esh;

        assign w_spos = w_slen - LW'(1) - LW'(k);
        assign w_epos = w_elen - LW'(1) - LW'(k);
        assign w_ssh  = r_start_key >> {w_spos, 3'b000};
        assign w_esh  = r_end_key >> {w_epos, 3'b000};

        always_comb begin
            w_key[k].start_kb = w_ssh[BW-1:0];
            w_key[k].start_en = LW'(k) < w_slen;
            w_key[k].end_kb   = w_esh[BW-1:0];
            w_key[k].end_en   = LW'(k) < w_elen;
        end

        if (k == 0) begin : g_head
            assign w_win_in[k] = s_axis_tdata;
        end else begin : g_link
            assign w_win_in[k] = w_win_out[k-1];
        end

        kdve_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_shift),
            .i_byte (w_win_in[k]),
            .i_key  (w_key[k]),
            .o_byte (w_win_out[k]),
            .o_hit  (w_hit[k])
        );

        assign w_start_eq[k] = w_hit[k].start_eq;
        assign w_end_eq[k]   = w_hit[k].end_eq;
    end

    assign w_start_all = &w_start_eq;
    assign w_end_all   = &w_end_eq;

    // byte leaving the end key window
    always_comb begin
        w_value = '0;
        for (int k = 0; k < MAX_KEY_BYTES; k++) begin
            if (w_elen_m1 == IW'(k)) begin
                w_value = w_win_in[k];
            end
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fill_p      = (r_fill == LW'(MAX_KEY_BYTES)) ? r_fill : r_fill + LW'(1);
    assign w_ph_eff      = (r_phase == kdve_pkg::PH_SKIP && r_offset >= r_skip)
                           ? kdve_pkg::PH_SEARCH : r_phase;
    assign w_shift       = w_accept && (w_ph_eff == kdve_pkg::PH_SEARCH ||
                                        w_ph_eff == kdve_pkg::PH_EXTRACT);

    always_comb begin
        n_phase          = r_phase;
        n_fill           = r_fill;
        n_offset         = r_offset;
        w_res_v          = 1'b0;
        w_res.kind       = kdve_pkg::KIND_VALUE;
        w_res.value_byte = '0;
        w_res.end_offset = '0;
        w_found_end      = 1'b0;
        if (w_accept) begin
            n_offset = r_offset + OW'(1);
            n_phase  = w_ph_eff;
            unique case (w_ph_eff)
                kdve_pkg::PH_SEARCH: begin
                    if (w_start_all && w_fill_p >= w_slen) begin
                        n_phase = kdve_pkg::PH_EXTRACT;
                        n_fill  = '0;
                    end else begin
                        n_fill = w_fill_p;
                    end
                end
                kdve_pkg::PH_EXTRACT: begin
                    n_fill = w_fill_p;
                    if (w_end_all && w_fill_p >= w_elen) begin
                        w_res_v          = 1'b1;
                        w_res.kind       = kdve_pkg::KIND_END_FOUND;
                        w_res.end_offset = r_offset + OW'(1) - OW'(w_elen);
                        n_phase          = kdve_pkg::PH_DONE;
                        w_found_end      = 1'b1;
                    end else if (w_fill_p >= w_elen && !s_axis_tlast) begin
                        w_res_v          = 1'b1;
                        w_res.value_byte = w_value;
                    end
                end
                default: ;
            endcase
            if (s_axis_tlast) begin
                if (!w_found_end) begin
                    if (n_phase == kdve_pkg::PH_SKIP || n_phase == kdve_pkg::PH_SEARCH) begin
                        w_res_v    = 1'b1;
                        w_res.kind = kdve_pkg::KIND_NO_START;
                    end else if (n_phase == kdve_pkg::PH_EXTRACT) begin
                        w_res_v          = 1'b1;
                        w_res.kind       = kdve_pkg::KIND_NO_END;
                        w_res.end_offset = r_offset + OW'(1) - OW'(w_elen);
                    end
                end
                n_phase  = kdve_pkg::PH_SKIP;
                n_fill   = '0;
                n_offset = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= kdve_pkg::PH_SKIP;
            r_fill   <= '0;
            r_offset <= '0;
        end else begin
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_offset <= n_offset;
        end
    end

    // two-entry output buffer: output register plus skid entry
    assign w_pop  = r_out_valid && m_axis_tready;
    assign w_push = w_accept && w_res_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || w_pop) begin
            r_out_valid <= w_push;
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || w_pop) begin
            if (w_push) begin
                r_out <= w_res;
            end
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.end_offset, r_out.value_byte};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.kind != kdve_pkg::KIND_VALUE;

    `KDVE_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid)
    `KDVE_ASSERT(a_fill_bounded, r_fill <= LW'(MAX_KEY_BYTES))
    `KDVE_ASSERT(a_stream_restart,
        (w_accept && s_axis_tlast) |=> (r_phase == kdve_pkg::PH_SKIP && r_offset == '0))
    `KDVE_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_out_valid && !r_skid_valid))

endmodule

// ===== sim/key_delimited_value_extractor_unit_test.sv =====
`timescale 1ns / 100ps

module key_delimited_value_extractor_unit_test;

    typedef struct packed {
        kdve_pkg::t_kind kind;
        logic [7:0]      value_byte;
        logic [31:0]     end_offset;
        logic            last;
    } t_extract_result;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_op;

    typedef struct packed {
        t_row_op                         op;
        logic [kdve_pkg::CFG_ADDR_W-1:0] addr;
        logic [kdve_pkg::CFG_DATA_W-1:0] data;   // register value, or the stream byte in 7:0
        logic                            fin;
        logic                            typed;  // expected result given in the row itself
        kdve_pkg::t_kind                 kind;
        logic [31:0]                     end_offset;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [kdve_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [kdve_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;   // data_byte
    logic                            s_axis_tlast = 1'b0; // stream_end
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [39:0]                     m_axis_tdata;        // value_byte, end_offset
    logic [1:0]                      m_axis_tuser;        // kind
    logic                            m_axis_tlast;        // last

    key_delimited_value_extractor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // register copies
    logic [63:0] sh_start_key = '0;
    logic [3:0]  sh_start_len = 4'd1;
    logic [63:0] sh_end_key   = '0;
    logic [3:0]  sh_end_len   = 4'd1;
    logic [31:0] sh_skip      = '0;

    // stream state of the extractor
    kdve_pkg::t_phase ph = kdve_pkg::PH_SKIP;
    logic [7:0]       win [8];
    int               win_fill = 0;
    logic [31:0]      stream_pos = '0;

    t_extract_result awaited_results [$];
    t_dir_row        dir_rows [$];
    int              error_count = 0;
    int              bytes_sent = 0;
    bit              quiet_flow = 1'b0;

    function automatic int eff_len(logic [3:0] len);
        if (len == 4'd0) return 1;
        if (len > 4'(kdve_pkg::MAX_KEY_BYTES)) return kdve_pkg::MAX_KEY_BYTES;
        return int'(len);
    endfunction

    function automatic t_extract_result mk_result(kdve_pkg::t_kind kind, logic [7:0] vb,
                                                  logic [31:0] off, logic last);
        t_extract_result r;
        r.kind       = kind;
        r.value_byte = vb;
        r.end_offset = off;
        r.last       = last;
        return r;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < 8; i++) win[i] = 8'h00;
        win_fill = 0;
    endfunction

    function automatic void shift_in(logic [7:0] b);
        for (int i = 7; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (win_fill < 8) win_fill++;
    endfunction

    // key's first byte lines up with the oldest window entry
    function automatic bit window_holds(logic [63:0] key, int len);
        if (win_fill < len) return 1'b0;
        for (int k = 0; k < len; k++)
            if (win[k] !== key[8*(len-1-k) +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int extractor_take_byte(logic [7:0] b, logic fin);
        int          slen;
        int          elen;
        int          made;
        logic [31:0] here;
        bit          found_end;
        slen      = eff_len(sh_start_len);
        elen      = eff_len(sh_end_len);
        here      = stream_pos;
        made      = 0;
        found_end = 1'b0;
        stream_pos = here + 32'd1;
        if (ph == kdve_pkg::PH_SKIP && here >= sh_skip) ph = kdve_pkg::PH_SEARCH;
        if (ph == kdve_pkg::PH_SEARCH) begin
            shift_in(b);
            if (window_holds(sh_start_key, slen)) begin
                ph = kdve_pkg::PH_EXTRACT;
                clear_window();
            end
        end else if (ph == kdve_pkg::PH_EXTRACT) begin
            shift_in(b);
            if (window_holds(sh_end_key, elen)) begin
                awaited_results.push_back(mk_result(kdve_pkg::KIND_END_FOUND, 8'h00,
                                                    here + 32'd1 - 32'(elen), 1'b1));
                made++;
                ph = kdve_pkg::PH_DONE;
                found_end = 1'b1;
            end else if (win_fill >= elen && !fin) begin
                awaited_results.push_back(mk_result(kdve_pkg::KIND_VALUE, win[elen-1],
                                                    '0, 1'b0));
                made++;
            end
        end
        if (fin) begin
            if (!found_end) begin
                if (ph == kdve_pkg::PH_SKIP || ph == kdve_pkg::PH_SEARCH) begin
                    awaited_results.push_back(mk_result(kdve_pkg::KIND_NO_START, 8'h00,
                                                        '0, 1'b1));
                    made++;
                end else if (ph == kdve_pkg::PH_EXTRACT) begin
                    awaited_results.push_back(mk_result(kdve_pkg::KIND_NO_END, 8'h00,
                                                        here + 32'd1 - 32'(elen), 1'b1));
                    made++;
                end
            end
            ph = kdve_pkg::PH_SKIP;
            clear_window();
            stream_pos = '0;
        end
        return made;
    endfunction

    // mostly short, now and then long
    function automatic int idle_span();
        int r;
        if (quiet_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [3:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 4'd0;
        if (r < 10) return 4'($urandom_range(9, 15));
        return 4'($urandom_range(1, 8));
    endfunction

    task automatic push_stream_byte(input logic [7:0] b, input logic fin, output int made);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? idle_span() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        made = extractor_take_byte(b, fin);
        bytes_sent++;
    endtask

    // stop sending, let every result out, then give the pipeline time to empty
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kdve_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            kdve_pkg::CFG_START_KEY:     sh_start_key = val;
            kdve_pkg::CFG_START_KEY_LEN: sh_start_len = val[3:0];
            kdve_pkg::CFG_END_KEY:       sh_end_key   = val;
            kdve_pkg::CFG_END_KEY_LEN:   sh_end_len   = val[3:0];
            kdve_pkg::CFG_SKIP_OFFSET:   sh_skip      = val[31:0];
            default: ;
        endcase
    endtask

    task automatic row_reg(input logic [kdve_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [63:0] val);
        t_dir_row r;
        r = '0;
        r.op   = ROW_REG;
        r.addr = idx;
        r.data = val;
        dir_rows.push_back(r);
    endtask

    task automatic row_byte(input logic [7:0] b, input logic fin);
        t_dir_row r;
        r = '0;
        r.op   = ROW_BYTE;
        r.data = {56'h0, b};
        r.fin  = fin;
        dir_rows.push_back(r);
    endtask

    task automatic row_checked(input logic [7:0] b, input logic fin,
                               input kdve_pkg::t_kind kind, input logic [31:0] off);
        t_dir_row r;
        r = '0;
        r.op         = ROW_BYTE;
        r.data       = {56'h0, b};
        r.fin        = fin;
        r.typed      = 1'b1;
        r.kind       = kind;
        r.end_offset = off;
        dir_rows.push_back(r);
    endtask

    task automatic setup_phase(input int idx);
        logic [63:0] sk;
        logic [63:0] ek;
        logic [3:0]  sl;
        logic [3:0]  el;
        logic [31:0] so;
        sk = {$urandom, $urandom};
        ek = {$urandom, $urandom};
        sl = pick_len();
        el = pick_len();
        case ($urandom_range(0, 9))
            0:       so = 32'hFFFF_FFFF;
            1:       so = $urandom;
            default: so = $urandom_range(0, 6);
        endcase
        case (idx)
            0: begin sk = '1; ek = '0; sl = 4'd8; el = 4'd8; so = '0; end
            1: begin sk = '0; ek = '1; sl = 4'd1; el = 4'd1; so = '0; end
            2: so = 32'hFFFF_FFFF;
            default: ;
        endcase
        settle_block();
        write_reg(kdve_pkg::CFG_START_KEY, sk);
        write_reg(kdve_pkg::CFG_START_KEY_LEN, {60'h0, sl});
        write_reg(kdve_pkg::CFG_END_KEY, ek);
        write_reg(kdve_pkg::CFG_END_KEY_LEN, {60'h0, el});
        write_reg(kdve_pkg::CFG_SKIP_OFFSET, {32'h0, so});
    endtask

    // mostly prefix, start key, value bytes, end key, trailer; the rest broken
    task automatic send_random_stream();
        logic [7:0] bytes_q [$];
        int         shape;
        int         n;
        int         slen;
        int         elen;
        int         cut;
        int         made;
        slen  = eff_len(sh_start_len);
        elen  = eff_len(sh_end_len);
        shape = $urandom_range(0, 99);
        n = (sh_skip < 32'd16) ? int'(sh_skip) : 0;
        n += $urandom_range(0, 3);
        repeat (n) bytes_q.push_back(8'($urandom));
        if (shape >= 10)
            for (int i = 0; i < slen; i++) bytes_q.push_back(sh_start_key[8*i +: 8]);
        repeat ($urandom_range(0, 12)) bytes_q.push_back(8'($urandom));
        if (shape >= 20)
            for (int i = 0; i < elen; i++) bytes_q.push_back(sh_end_key[8*i +: 8]);
        repeat ($urandom_range(0, 2)) bytes_q.push_back(8'($urandom));
        if (shape >= 90 && bytes_q.size() > 0) begin
            cut = $urandom_range(1, bytes_q.size());
            while (bytes_q.size() > cut) void'(bytes_q.pop_back());
        end
        if (bytes_q.size() == 0) bytes_q.push_back(8'($urandom));
        for (int i = 0; i < bytes_q.size(); i++)
            push_stream_byte(bytes_q[i], i == bytes_q.size() - 1, made);
    endtask

    // result checking and output stalls
    initial begin
        t_extract_result got;
        t_extract_result want;
        int              stall_cnt;
        stall_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                got.kind       = kdve_pkg::t_kind'(m_axis_tuser);
                got.value_byte = m_axis_tdata[7:0];
                got.end_offset = m_axis_tdata[39:8];
                got.last       = m_axis_tlast;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: kind %0d value %02h offset %08h last %0b",
                             $time, got.kind, got.value_byte, got.end_offset, got.last);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.kind !== want.kind || got.value_byte !== want.value_byte ||
                        got.end_offset !== want.end_offset || got.last !== want.last) begin
                        $display("%0t: expected kind %0d value %02h offset %08h last %0b",
                                 $time, want.kind, want.value_byte, want.end_offset,
                                 want.last);
                        $display("%0t: got      kind %0d value %02h offset %08h last %0b",
                                 $time, got.kind, got.value_byte, got.end_offset,
                                 got.last);
                        error_count++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_cnt = ($urandom_range(0, 3) == 0) ? idle_span() : 0;
            end
        end
    end

    initial begin
        int made;
        int phase_idx;
        clear_window();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers
        row_checked(8'hFF, 1'b1, kdve_pkg::KIND_NO_START, 32'h0);
        row_checked(8'h00, 1'b1, kdve_pkg::KIND_NO_END, 32'h0);  // start key on the final byte
        row_byte(8'h00, 1'b0);
        row_byte(8'hFF, 1'b0);
        row_checked(8'h00, 1'b1, kdve_pkg::KIND_END_FOUND, 32'h2);
        // two byte start key, end key length zero counts as one, skip one byte
        row_reg(kdve_pkg::CFG_START_KEY, 64'hDEAD_BEEF_0000_BBAA);
        row_reg(kdve_pkg::CFG_START_KEY_LEN, 64'd2);
        row_reg(kdve_pkg::CFG_END_KEY, 64'h1234_5678_9ABC_DEEE);
        row_reg(kdve_pkg::CFG_END_KEY_LEN, 64'd0);
        row_reg(kdve_pkg::CFG_SKIP_OFFSET, 64'd1);
        row_byte(8'hAA, 1'b0);
        row_byte(8'hBB, 1'b0);
        row_byte(8'hAA, 1'b0);
        row_byte(8'hBB, 1'b0);
        row_byte(8'h12, 1'b0);
        row_checked(8'hEE, 1'b0, kdve_pkg::KIND_END_FOUND, 32'h5);
        row_byte(8'h77, 1'b1);                            // ignored after the end key
        row_reg(kdve_pkg::CFG_SKIP_OFFSET, 64'hFFFF_FFFF);
        row_checked(8'h00, 1'b1, kdve_pkg::KIND_NO_START, 32'h0);
        // end key length above the maximum counts as eight; offsets wrap
        row_reg(kdve_pkg::CFG_SKIP_OFFSET, 64'd0);
        row_reg(kdve_pkg::CFG_START_KEY, 64'hFFFF_FFFF_FFFF_FF5A);
        row_reg(kdve_pkg::CFG_START_KEY_LEN, 64'd1);
        row_reg(kdve_pkg::CFG_END_KEY, 64'hFFFF_FFFF_FFFF_FFFF);
        row_reg(kdve_pkg::CFG_END_KEY_LEN, 64'd15);
        row_checked(8'h5A, 1'b1, kdve_pkg::KIND_NO_END, 32'hFFFF_FFF9);
        row_byte(8'h5A, 1'b0);
        row_checked(8'h01, 1'b1, kdve_pkg::KIND_NO_END, 32'hFFFF_FFFA);
        row_byte(8'h5A, 1'b0);
        repeat (7) row_byte(8'hFF, 1'b0);
        row_checked(8'hFF, 1'b0, kdve_pkg::KIND_END_FOUND, 32'h1);
        row_byte(8'h00, 1'b1);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_REG) begin
                settle_block();
                write_reg(dir_rows[i].addr, dir_rows[i].data);
            end else begin
                push_stream_byte(dir_rows[i].data[7:0], dir_rows[i].fin, made);
                if (dir_rows[i].typed) begin
                    repeat (made) void'(awaited_results.pop_back());
                    awaited_results.push_back(mk_result(dir_rows[i].kind, 8'h00,
                                                        dir_rows[i].end_offset, 1'b1));
                end
            end
        end

        phase_idx = 0;
        while (bytes_sent < 1800) begin
            setup_phase(phase_idx);
            quiet_flow = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 9)) begin
                send_random_stream();
                if ($urandom_range(0, 9) == 0) settle_block();
            end
            phase_idx++;
        end

        settle_block();
        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("key_delimited_value_extractor_unit test passed");
        end else begin
            $display("key_delimited_value_extractor_unit test failed");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("key_delimited_value_extractor_unit test failed");
        $finish;
    end

endmodule
